// ===== design/assert_macros.svh =====
// Assertion macros used by the encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under active-low reset
`define EFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under active-low reset
`define EFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define EFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/efe_pkg.sv =====
// Shared types and constants for the Elias-Fano encoder.
package efe_pkg;

    localparam int          CFG_W          = 5;
    localparam logic [4:0]  LOW_BITS_RESET = 5'd6;
    localparam int          IN_DATA_W      = 32;
    localparam int          OUT_DATA_W     = 48;

    localparam logic STREAM_UPPER = 1'b0;
    localparam logic STREAM_LOWER = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DECREASE = 2'd1,
        ERR_GAP      = 2'd2
    } t_err_code;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_UPPER,
        S_LOWER,
        S_FLUSH_UP,
        S_FLUSH_LO
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic check;
        logic up_step;
        logic lo_step;
        logic flush_up;
        logic flush_lo;
    } t_ctl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic err_any;
        logic up_done;
        logic lo_done;
        logic last;
    } t_dp_status;

endpackage

// ===== design/efe_controller.sv =====
// Sequencer for the encoder: check, upper bytes, lower bytes, flushes.
module efe_controller
    import efe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_sts,
    output logic       o_in_ready,
    output t_ctl_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.err_any ? S_IDLE : S_UPPER;
                end
            end
            S_UPPER: begin
                if (i_sts.out_free && i_sts.up_done) begin
                    n_state = S_LOWER;
                end
            end
            S_LOWER: begin
                if (i_sts.out_free && i_sts.lo_done) begin
                    n_state = i_sts.last ? S_FLUSH_UP : S_IDLE;
                end
            end
            S_FLUSH_UP: begin
                if (i_sts.out_free) begin
                    n_state = S_FLUSH_LO;
                end
            end
            S_FLUSH_LO: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands; every datapath step waits for room in the output register
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.check = i_sts.out_free;
            end
            S_UPPER: begin
                o_cmd.up_step = i_sts.out_free;
            end
            S_LOWER: begin
                o_cmd.lo_step = i_sts.out_free;
            end
            S_FLUSH_UP: begin
                o_cmd.flush_up = i_sts.out_free;
            end
            S_FLUSH_LO: begin
                o_cmd.flush_lo = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/efe_datapath.sv =====
// Encoder datapath: split, gap check, byte packing, totals, output register.
module efe_datapath
    import efe_pkg::*;
#(
    parameter int MAX_GAP      = 32,
    parameter int MAX_LOW_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic [IN_DATA_W-1:0]  i_in_value,
    input  logic                  i_in_last,
    input  t_ctl_cmd              i_cmd,
    output t_dp_status            o_sts,
    input  logic                  i_m_axis_tready,
    output logic                  o_m_axis_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tuser,
    output logic                  o_m_axis_tlast
);

    localparam int GW = $clog2(MAX_GAP + 2);       // holds gap + 1
    localparam int NW = $clog2(MAX_LOW_BITS + 1);  // holds low bit count

    // Configuration and latched input
    logic [CFG_W-1:0]        r_low_bits;
    logic [31:0]             r_value, n_value;
    logic                    r_last, n_last;
    logic [NW-1:0]           r_l, n_l;
    // Encoder state
    logic [31:0]             r_prev_high, n_prev_high;
    logic [6:0]              r_up_bits, n_up_bits;
    logic [2:0]              r_up_cnt, n_up_cnt;
    logic [6:0]              r_lo_bits, n_lo_bits;
    logic [2:0]              r_lo_cnt, n_lo_cnt;
    logic [31:0]             r_up_total, n_up_total;
    logic [31:0]             r_lo_total, n_lo_total;
    // Per-item work counters
    logic [GW-1:0]           r_up_rem, n_up_rem;
    logic [NW-1:0]           r_lo_n, n_lo_n;
    logic [MAX_LOW_BITS-1:0] r_lo_word, n_lo_word;
    logic                    r_lo_will, n_lo_will;
    // Output register
    logic                    r_o_valid, n_o_valid;
    logic                    r_o_sid, n_o_sid;
    logic [7:0]              r_o_byte, n_o_byte;
    logic [3:0]              r_o_cnt, n_o_cnt;
    logic [31:0]             r_o_total, n_o_total;
    t_err_code               r_o_err, n_o_err;
    logic                    r_o_end, n_o_end;

    logic                    w_out_free;
    logic [NW-1:0]           w_l_in;
    logic [31:0]             w_high;
    logic [31:0]             w_gap;
    t_err_code               w_err;
    logic                    w_lo_will;
    // Upper stream step
    logic [3:0]              w_up_free;
    logic [GW-1:0]           w_up_bits_left;
    logic                    w_up_full;
    logic [3:0]              w_up_k;
    logic [15:0]             w_up_ones_k;
    logic [7:0]              w_up_byte;
    logic                    w_up_zero_in;
    logic [2:0]              w_up_rem3;
    logic [6:0]              w_up_absorb;
    // Lower stream step
    logic [3:0]              w_lo_free;
    logic                    w_lo_full;
    logic [NW-1:0]           w_lo_shift;
    logic [7:0]              w_lo_mask;
    logic [7:0]              w_lo_chunk;
    logic [7:0]              w_lo_byte;
    logic [2:0]              w_lo_n3;
    logic [6:0]              w_lo_absorb;
    // Flush bytes
    logic [7:0]              w_up_flush;
    logic [7:0]              w_lo_flush;

    assign w_out_free = !r_o_valid || i_m_axis_tready;

    // Effective low bit width, saturated
    assign w_l_in = (r_low_bits > CFG_W'(MAX_LOW_BITS)) ? NW'(MAX_LOW_BITS)
                                                        : NW'(r_low_bits);

    // Split and gap check on the latched value
    always_comb begin
        w_high    = r_value >> r_l;
        w_gap     = w_high - r_prev_high;
        w_lo_will = (6'(r_lo_cnt) + 6'(r_l)) >= 6'd8;
        if (w_high < r_prev_high) begin
            w_err = ERR_DECREASE;
        end else if (w_gap > 32'(MAX_GAP)) begin
            w_err = ERR_GAP;
        end else begin
            w_err = ERR_NONE;
        end
    end

    // Upper stream: remaining ones, then a zero
    always_comb begin
        w_up_free      = 4'd8 - 4'(r_up_cnt);
        w_up_bits_left = r_up_rem + GW'(1);
        w_up_full      = 8'(w_up_bits_left) >= 8'(w_up_free);
        w_up_k         = (8'(r_up_rem) >= 8'(w_up_free)) ? w_up_free : 4'(r_up_rem);
        w_up_ones_k    = (16'd1 << w_up_k) - 16'd1;
        w_up_byte      = 8'(({9'd0, r_up_bits} << w_up_free)
                           | (w_up_ones_k << (w_up_free - w_up_k)));
        w_up_zero_in   = w_up_k < w_up_free;
        w_up_rem3      = 3'(w_up_bits_left);
        w_up_absorb    = 7'(({9'd0, r_up_bits} << w_up_rem3)
                           | (((16'd1 << 4'(r_up_rem)) - 16'd1) << 1));
    end

    // Lower stream: remaining low bits, MSB first
    always_comb begin
        w_lo_free   = 4'd8 - 4'(r_lo_cnt);
        w_lo_full   = 8'(r_lo_n) >= 8'(w_lo_free);
        w_lo_shift  = r_lo_n - NW'(w_lo_free);
        w_lo_mask   = 8'((16'd1 << w_lo_free) - 16'd1);
        w_lo_chunk  = 8'(r_lo_word >> w_lo_shift) & w_lo_mask;
        w_lo_byte   = 8'({9'd0, r_lo_bits} << w_lo_free) | w_lo_chunk;
        w_lo_n3     = 3'(r_lo_n);
        w_lo_absorb = 7'(({9'd0, r_lo_bits} << w_lo_n3)
                        | (16'(r_lo_word) & ((16'd1 << w_lo_n3) - 16'd1)));
    end

    // Partial bytes left-aligned for the flush
    assign w_up_flush = 8'({9'd0, r_up_bits} << (4'd8 - 4'(r_up_cnt)));
    assign w_lo_flush = 8'({9'd0, r_lo_bits} << (4'd8 - 4'(r_lo_cnt)));

    // Next-state logic for the datapath
    always_comb begin
        n_value     = r_value;
        n_last      = r_last;
        n_l         = r_l;
        n_prev_high = r_prev_high;
        n_up_bits   = r_up_bits;
        n_up_cnt    = r_up_cnt;
        n_lo_bits   = r_lo_bits;
        n_lo_cnt    = r_lo_cnt;
        n_up_total  = r_up_total;
        n_lo_total  = r_lo_total;
        n_up_rem    = r_up_rem;
        n_lo_n      = r_lo_n;
        n_lo_word   = r_lo_word;
        n_lo_will   = r_lo_will;
        n_o_valid   = r_o_valid && !i_m_axis_tready;
        n_o_sid     = r_o_sid;
        n_o_byte    = r_o_byte;
        n_o_cnt     = r_o_cnt;
        n_o_total   = r_o_total;
        n_o_err     = r_o_err;
        n_o_end     = r_o_end;

        if (i_cmd.load) begin
            n_value = i_in_value;
            n_last  = i_in_last;
            n_l     = w_l_in;
        end

        if (i_cmd.check) begin
            if (w_err != ERR_NONE) begin
                // Error beat, state untouched
                n_o_valid = 1'b1;
                n_o_sid   = STREAM_UPPER;
                n_o_byte  = 8'd0;
                n_o_cnt   = 4'd0;
                n_o_total = 32'd0;
                n_o_err   = w_err;
                n_o_end   = 1'b1;
            end else begin
                n_prev_high = w_high;
                n_up_total  = r_up_total + 32'(w_gap[GW-1:0]) + 32'd1;
                n_lo_total  = r_lo_total + 32'(r_l);
                n_up_rem    = w_gap[GW-1:0];
                n_lo_n      = r_l;
                n_lo_word   = r_value[MAX_LOW_BITS-1:0];
                n_lo_will   = w_lo_will;
            end
        end

        if (i_cmd.up_step) begin
            if (w_up_full) begin
                n_o_valid = 1'b1;
                n_o_sid   = STREAM_UPPER;
                n_o_byte  = w_up_byte;
                n_o_cnt   = 4'd8;
                n_o_total = 32'd0;
                n_o_err   = ERR_NONE;
                // Final beat if not last, no lower byte due, < 8 upper bits left
                n_o_end   = !r_last && !r_lo_will
                            && (8'(w_up_bits_left) < 8'(w_up_free) + 8'd8);
                n_up_bits = 7'd0;
                n_up_cnt  = 3'd0;
                n_up_rem  = r_up_rem - GW'(w_up_k);
            end else begin
                n_up_bits = w_up_absorb;
                n_up_cnt  = r_up_cnt + w_up_rem3;
            end
        end

        if (i_cmd.lo_step) begin
            if (w_lo_full) begin
                n_o_valid = 1'b1;
                n_o_sid   = STREAM_LOWER;
                n_o_byte  = w_lo_byte;
                n_o_cnt   = 4'd8;
                n_o_total = 32'd0;
                n_o_err   = ERR_NONE;
                n_o_end   = !r_last && (8'(w_lo_shift) < 8'd8);
                n_lo_bits = 7'd0;
                n_lo_cnt  = 3'd0;
                n_lo_n    = w_lo_shift;
            end else begin
                n_lo_bits = w_lo_absorb;
                n_lo_cnt  = r_lo_cnt + w_lo_n3;
            end
        end

        if (i_cmd.flush_up) begin
            n_o_valid = 1'b1;
            n_o_sid   = STREAM_UPPER;
            n_o_byte  = w_up_flush;
            n_o_cnt   = 4'(r_up_cnt);
            n_o_total = r_up_total;
            n_o_err   = ERR_NONE;
            n_o_end   = 1'b0;
        end

        if (i_cmd.flush_lo) begin
            n_o_valid   = 1'b1;
            n_o_sid     = STREAM_LOWER;
            n_o_byte    = w_lo_flush;
            n_o_cnt     = 4'(r_lo_cnt);
            n_o_total   = r_lo_total;
            n_o_err     = ERR_NONE;
            n_o_end     = 1'b1;
            // Sequence over: back to the reset state
            n_prev_high = 32'd0;
            n_up_bits   = 7'd0;
            n_up_cnt    = 3'd0;
            n_lo_bits   = 7'd0;
            n_lo_cnt    = 3'd0;
            n_up_total  = 32'd0;
            n_lo_total  = 32'd0;
        end
    end

    // Control and encoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_bits  <= LOW_BITS_RESET;
            r_prev_high <= 32'd0;
            r_up_bits   <= 7'd0;
            r_up_cnt    <= 3'd0;
            r_lo_bits   <= 7'd0;
            r_lo_cnt    <= 3'd0;
            r_up_total  <= 32'd0;
            r_lo_total  <= 32'd0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_low_bits <= i_cfg_wdata;
            end
            r_prev_high <= n_prev_high;
            r_up_bits   <= n_up_bits;
            r_up_cnt    <= n_up_cnt;
            r_lo_bits   <= n_lo_bits;
            r_lo_cnt    <= n_lo_cnt;
            r_up_total  <= n_up_total;
            r_lo_total  <= n_lo_total;
            r_o_valid   <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_last    <= n_last;
        r_l       <= n_l;
        r_up_rem  <= n_up_rem;
        r_lo_n    <= n_lo_n;
        r_lo_word <= n_lo_word;
        r_lo_will <= n_lo_will;
        r_o_sid   <= n_o_sid;
        r_o_byte  <= n_o_byte;
        r_o_cnt   <= n_o_cnt;
        r_o_total <= n_o_total;
        r_o_err   <= n_o_err;
        r_o_end   <= n_o_end;
    end

    // Status to the controller
    always_comb begin
        o_sts.out_free = w_out_free;
        o_sts.err_any  = w_err != ERR_NONE;
        o_sts.up_done  = !w_up_full || w_up_zero_in;
        o_sts.lo_done  = !w_lo_full;
        o_sts.last     = r_last;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {2'b00, r_o_err, r_o_total, r_o_cnt, r_o_byte};
    assign o_m_axis_tuser  = r_o_sid;
    assign o_m_axis_tlast  = r_o_end;

endmodule

// ===== design/elias_fano_encoder_core.sv =====
// Elias-Fano encoder top level: controller, datapath and checks.
// Flow: a value is accepted, then checked; the upper stream then emits its full upper bytes and
// absorbs its remaining bits unless its closing zero fills a byte, and the lower stream emits its
// full lower bytes and absorbs the rest; a last value adds the upper and lower flush beats, and
// an error value ends after the check. Packing forms one byte per cycle while the output register
// has room, and output stalls hold it; a new value is taken only once the previous one is done.
// Reset (i_rst_n low at a clock edge, synchronous) clears encoder state, sets low_bits to 6.
`include "assert_macros.svh"
module elias_fano_encoder_core
    import efe_pkg::*;
#(
    parameter int MAX_GAP      = 32,
    parameter int MAX_LOW_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration: low_bits
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // Input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [31:0] value
    input  logic                  i_s_axis_tlast,   // last_value
    // Output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [7:0] packed_byte, [11:8] valid_bit_count, [43:12] stream_bit_total,
    // [45:44] error_code, [47:46] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tuser,   // [0] stream_id
    output logic                  o_m_axis_tlast    // run_end
);

    t_ctl_cmd   w_cmd;
    t_dp_status w_sts;

    efe_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    efe_datapath #(
        .MAX_GAP      (MAX_GAP),
        .MAX_LOW_BITS (MAX_LOW_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_value      (i_s_axis_tdata),
        .i_in_last       (i_s_axis_tlast),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // One value in flight: no second beat right after an accepted one
    `EFE_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input accepted while busy")
    // An error beat ends its run and carries no bits
    `EFE_ASSERT_IMPL(a_err_beat, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tdata[45:44] != ERR_NONE), o_m_axis_tlast && (o_m_axis_tdata[11:8] == 4'd0) && (o_m_axis_tdata[43:12] == 32'd0), "malformed error beat")
    // Datapath steps only when the output register has room
    `EFE_ASSERT_IMPL(a_step_room, i_clk, i_rst_n, w_cmd.check || w_cmd.up_step || w_cmd.lo_step || w_cmd.flush_up || w_cmd.flush_lo, w_sts.out_free, "step without output room")
    // Bit count never exceeds a byte
    `EFE_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[11:8] <= 4'd8, "bit count above 8")

endmodule
